@@ design/tmef_pkg.sv @@
// Shared types and constants for the temperature median/EMA fault filter.
`timescale 1ns / 1ps

package tmef_pkg;

	localparam int TEMP_W    = 13;
	localparam int TIME_W    = 32;
	localparam int RATE_W    = 12;
	localparam int TMO_W     = 16;
	localparam int TRIP_W    = 8;
	localparam int ALPHA_W   = 9;
	localparam int CNT_W     = 8;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int ALPHA_SHIFT = 8;     // alpha is Q8
	localparam int MS_PER_S  = 1000;

	typedef logic signed [TEMP_W-1:0] temp_t;

	localparam temp_t TEMP_SENTINEL = -13'sd2032;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	typedef enum logic [2:0] {
		REG_LOW     = 3'd0,
		REG_HIGH    = 3'd1,
		REG_RATE    = 3'd2,
		REG_TIMEOUT = 3'd3,
		REG_TRIP    = 3'd4,
		REG_ALPHA   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_READ  = 2'd1,
		FAULT_DISC  = 2'd2,
		FAULT_RANGE = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		CM_HOLD = 2'd0,
		CM_LOAD = 2'd1,
		CM_MIN  = 2'd2,
		CM_MAX  = 2'd3
	} cell_mode_t;

	typedef struct packed {
		temp_t               low;
		temp_t               high;
		logic [RATE_W-1:0]   rate;
		logic [TMO_W-1:0]    timeout;
		logic [TRIP_W-1:0]   trip;
		logic [ALPHA_W-1:0]  alpha;
	} cfg_t;

endpackage

@@ design/temp_median_ema_fault_filter.sv @@
// Top level: sample window, median sort row, range/rate checks, EMA and fault tracking.
//
//  channel   handshake                       payload
//  config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//  input     in_valid / in_ready             sample_temp, time_ms
//  output    out_valid / out_ready           smoothed_temp, temp_valid, fault_kind,
//                                            failures_seen
//
// Steps: a sample that arrives while the window fills, or a read-failure sample,
// goes from transfer straight to the commit step; with a full window it passes through
// WINDOW sort phases in the cell row, then check, multiply, EMA and commit.
// One sample is in work at a time; in_ready is high only in the idle state.
// Reset clears all filter state at once; no clearing pass.
// A result that waits on out_ready holds the commit step until the output register frees.
`timescale 1ns / 1ps

module temp_median_ema_fault_filter #(
	parameter int WINDOW        = 5,
	parameter int EMA_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmef_pkg::PADDR_W-1:0]  paddr,
	input  logic [tmef_pkg::PDATA_W-1:0]  pwdata,
	output logic [tmef_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [12:0]            sample_temp,
	input  logic [31:0]                   time_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [12:0]            smoothed_temp,
	output logic                          temp_valid,
	output logic [1:0]                    fault_kind,
	output logic [7:0]                    failures_seen
);

	localparam int FILL_W  = $clog2(WINDOW + 1);
	localparam int PH_W    = $clog2(WINDOW);
	localparam int MED_IDX = WINDOW / 2;
	localparam int EMA_W   = tmef_pkg::TEMP_W + EMA_FRAC_BITS;
	localparam int DIFF_W  = EMA_W + 1;
	localparam int PROD_W  = DIFF_W + tmef_pkg::ALPHA_W + 1;
	localparam int ACC_W   = EMA_W + 12;
	localparam int RND_W   = EMA_W + 1;
	localparam int HALF    = 1 << (EMA_FRAC_BITS - 1);
	localparam int AD_W    = tmef_pkg::TEMP_W + 1;
	localparam int AD1K_W  = 24;
	localparam int RDT_W   = tmef_pkg::RATE_W + tmef_pkg::TIME_W;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
	localparam logic [PH_W-1:0]   PH_LAST   = PH_W'(WINDOW - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SORT  = 6'b000010,
		S_CHECK = 6'b000100,
		S_MUL   = 6'b001000,
		S_EMA   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	typedef logic signed [EMA_W-1:0] ema_t;

	function automatic ema_t scale_up(input tmef_pkg::temp_t t);
		scale_up = $signed({t, {EMA_FRAC_BITS{1'b0}}});
	endfunction

	tmef_pkg::cfg_t cfg;

	tmef_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// control
	state_t               state_q;
	logic [PH_W-1:0]      phase_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 in_fire;
	logic                 out_free;

	// filter state
	ema_t                 ema_q;
	tmef_pkg::temp_t      filt_q;
	tmef_pkg::temp_t      last_med_q;
	logic [31:0]          last_good_q;
	logic [7:0]           fail_cnt_q;
	tmef_pkg::fault_t     fault_q;
	logic                 valid_q;

	// per-sample working registers
	tmef_pkg::temp_t      win_q [WINDOW-1];
	tmef_pkg::temp_t      srt [WINDOW];
	logic [31:0]          now_q;
	logic [31:0]          dt_q;
	tmef_pkg::temp_t      med_q;
	logic                 plaus_q;
	logic [AD1K_W-1:0]    ad1k_q;
	logic [RDT_W-1:0]     rdt_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                 ok_q;
	logic                 pass_q;
	logic                 upd_med_q;
	tmef_pkg::fault_t     code_q;
	tmef_pkg::temp_t      value_q;
	ema_t                 ema_nxt_q;

	// output register
	logic                 out_valid_q;
	tmef_pkg::temp_t      out_temp_q;
	logic                 out_tv_q;
	tmef_pkg::fault_t     out_fault_q;
	logic [7:0]           out_cnt_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// ---------------- sort row ----------------
	// The newest sample loads straight into cell 0; the older ones come from the window.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		tmef_pkg::temp_t      left_w;
		tmef_pkg::temp_t      right_w;
		tmef_pkg::temp_t      ld_w;
		tmef_pkg::cell_mode_t mode_w;

		if (i == 0) begin : g_first
			assign left_w = srt[i];
			assign ld_w   = sample_temp;
		end else begin : g_rest
			assign left_w = srt[i-1];
			assign ld_w   = win_q[i-1];
		end

		if (i == WINDOW - 1) begin : g_last
			assign right_w = srt[i];
		end else begin : g_inner
			assign right_w = srt[i+1];
		end

		always_comb begin
			mode_w = tmef_pkg::CM_HOLD;
			if (in_fire) begin
				mode_w = tmef_pkg::CM_LOAD;
			end else if (state_q == S_SORT) begin
				if (phase_q[0] == 1'(i % 2)) begin
					if (i < WINDOW - 1) mode_w = tmef_pkg::CM_MIN;
				end else begin
					if (i > 0) mode_w = tmef_pkg::CM_MAX;
				end
			end
		end

		tmef_cell u_cell (
			.clk      (clk),
			.mode     (mode_w),
			.load_val (ld_w),
			.left     (left_w),
			.right    (right_w),
			.val      (srt[i])
		);
	end

	// ---------------- window shift line ----------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			win_q[0] <= sample_temp;
			for (int i = 1; i < WINDOW - 1; i++) win_q[i] <= win_q[i-1];
		end
	end

	// ---------------- datapath decisions ----------------
	logic [FILL_W-1:0]    fill_n;
	logic                 filling;
	logic                 samp_plaus;
	tmef_pkg::temp_t      med;
	logic signed [AD_W-1:0] dmed;
	logic [AD_W-1:0]      admed;
	logic                 rate_skip;
	logic signed [ACC_W-1:0] acc;
	ema_t                 ema_avg;
	ema_t                 ema_new;
	logic signed [RND_W-1:0] rnd;
	logic [7:0]           cnt_inc;

	always_comb begin
		fill_n     = (fill_q < FILL_FULL) ? fill_q + 1'b1 : fill_q;
		filling    = (fill_n < FILL_FULL);
		samp_plaus = (sample_temp >= cfg.low) && (sample_temp <= cfg.high);

		med   = srt[MED_IDX];
		dmed  = AD_W'(med) - AD_W'(last_med_q);
		admed = dmed[AD_W-1] ? AD_W'(-dmed) : AD_W'(dmed);

		rate_skip = ~valid_q || (last_med_q == '0) || (dt_q == '0);

		acc     = (ACC_W'(ema_q) <<< tmef_pkg::ALPHA_SHIFT) + ACC_W'(prod_q)
		        + ACC_W'(1 << (tmef_pkg::ALPHA_SHIFT - 1));
		ema_avg = EMA_W'(acc >>> tmef_pkg::ALPHA_SHIFT);
		ema_new = valid_q ? ema_avg : scale_up(med_q);
		rnd     = RND_W'(ema_new) + RND_W'(HALF);

		cnt_inc = (fail_cnt_q < tmef_pkg::CNT_MAX) ? fail_cnt_q + 8'd1 : fail_cnt_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					now_q     <= time_ms;
					dt_q      <= time_ms - last_good_q;
					upd_med_q <= 1'b0;
					value_q   <= sample_temp;
					ema_nxt_q <= scale_up(sample_temp);
					if (sample_temp == tmef_pkg::TEMP_SENTINEL) begin
						pass_q <= 1'b0;
						code_q <= tmef_pkg::FAULT_READ;
					end else begin
						pass_q <= samp_plaus;
						code_q <= tmef_pkg::FAULT_RANGE;
					end
				end
			end
			S_SORT: ;
			S_CHECK: begin
				med_q   <= med;
				plaus_q <= (med >= cfg.low) && (med <= cfg.high);
				ad1k_q  <= AD1K_W'(admed) * AD1K_W'(tmef_pkg::MS_PER_S);
				rdt_q   <= RDT_W'(cfg.rate) * RDT_W'(dt_q);
				diff_q  <= DIFF_W'(scale_up(med)) - DIFF_W'(ema_q);
			end
			S_MUL: begin
				ok_q   <= plaus_q && (rate_skip || (RDT_W'(ad1k_q) <= rdt_q));
				prod_q <= PROD_W'($signed({1'b0, cfg.alpha})) * PROD_W'(diff_q);
			end
			S_EMA: begin
				pass_q    <= ok_q;
				code_q    <= tmef_pkg::FAULT_RANGE;
				upd_med_q <= 1'b1;
				ema_nxt_q <= ema_new;
				value_q   <= rnd[EMA_FRAC_BITS +: tmef_pkg::TEMP_W];
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// ---------------- commit values ----------------
	tmef_pkg::temp_t  filt_n;
	logic             valid_n;
	tmef_pkg::fault_t fault_n;
	logic [7:0]       cnt_n;

	always_comb begin
		filt_n  = filt_q;
		valid_n = valid_q;
		fault_n = fault_q;
		cnt_n   = fail_cnt_q;
		if (pass_q) begin
			filt_n  = value_q;
			valid_n = 1'b1;
			fault_n = tmef_pkg::FAULT_NONE;
			cnt_n   = '0;
		end else begin
			cnt_n = cnt_inc;
			priority if (dt_q >= 32'(cfg.timeout)) begin
				valid_n = 1'b0;
				fault_n = tmef_pkg::FAULT_DISC;
			end else if (cnt_inc >= cfg.trip) begin
				valid_n = 1'b0;
				fault_n = code_q;
			end
		end
	end

	// ---------------- sequencer and filter state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			fill_q      <= '0;
			ema_q       <= '0;
			filt_q      <= '0;
			last_med_q  <= '0;
			last_good_q <= '0;
			fail_cnt_q  <= '0;
			fault_q     <= tmef_pkg::FAULT_NONE;
			valid_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the commit step reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					phase_q <= '0;
					if (in_fire) begin
						fill_q <= fill_n;
						// a failed read or a filling window skips the median
						if (sample_temp == tmef_pkg::TEMP_SENTINEL || filling) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SORT;
						end
					end
				end
				S_SORT: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == PH_LAST) state_q <= S_CHECK;
				end
				S_CHECK: state_q <= S_MUL;
				S_MUL:   state_q <= S_EMA;
				S_EMA:   state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						filt_q      <= filt_n;
						valid_q     <= valid_n;
						fault_q     <= fault_n;
						fail_cnt_q  <= cnt_n;
						out_valid_q <= 1'b1;
						if (pass_q) begin
							ema_q       <= ema_nxt_q;
							last_good_q <= now_q;
							if (upd_med_q) last_med_q <= med_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_temp_q  <= filt_n;
			out_tv_q    <= valid_n;
			out_fault_q <= fault_n;
			out_cnt_q   <= cnt_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign smoothed_temp = out_temp_q;
	assign temp_valid    = out_tv_q;
	assign fault_kind    = out_fault_q;
	assign failures_seen = out_cnt_q;

endmodule

@@ design/tmef_cell.sv @@
// One compare-exchange cell of the odd-even transposition sort row.
`timescale 1ns / 1ps

module tmef_cell (
	input  logic                 clk,
	input  tmef_pkg::cell_mode_t mode,
	input  tmef_pkg::temp_t      load_val,
	input  tmef_pkg::temp_t      left,
	input  tmef_pkg::temp_t      right,
	output tmef_pkg::temp_t      val
);

	tmef_pkg::temp_t val_q;

	always_ff @(posedge clk) begin
		unique case (mode)
			tmef_pkg::CM_LOAD: val_q <= load_val;
			// left member of a pair keeps the smaller value, right member the larger
			tmef_pkg::CM_MIN:  val_q <= (right < val_q) ? right : val_q;
			tmef_pkg::CM_MAX:  val_q <= (left > val_q) ? left : val_q;
			default:           val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

@@ design/tmef_regs.sv @@
// APB-style configuration register file of the fault filter.
`timescale 1ns / 1ps

module tmef_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmef_pkg::PADDR_W-1:0]  paddr,
	input  logic [tmef_pkg::PDATA_W-1:0]  pwdata,
	output logic [tmef_pkg::PDATA_W-1:0]  prdata,
	output tmef_pkg::cfg_t                cfg
);

	tmef_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx   = paddr[4:2];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low     <= -13'sd160;
			cfg_q.high    <= 13'sd2400;
			cfg_q.rate    <= 12'd80;
			cfg_q.timeout <= 16'd2000;
			cfg_q.trip    <= 8'd3;
			cfg_q.alpha   <= 9'd51;
		end else if (wr_en) begin
			case (idx)
				tmef_pkg::REG_LOW:     cfg_q.low     <= pwdata[12:0];
				tmef_pkg::REG_HIGH:    cfg_q.high    <= pwdata[12:0];
				tmef_pkg::REG_RATE:    cfg_q.rate    <= pwdata[11:0];
				tmef_pkg::REG_TIMEOUT: cfg_q.timeout <= pwdata[15:0];
				tmef_pkg::REG_TRIP:    cfg_q.trip    <= pwdata[7:0];
				tmef_pkg::REG_ALPHA: begin
					// clamp the weight to 1.0
					cfg_q.alpha <= (pwdata[8:0] > tmef_pkg::ALPHA_ONE) ?
						tmef_pkg::ALPHA_ONE : pwdata[8:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tmef_pkg::REG_LOW:     prdata = {19'd0, cfg_q.low};
			tmef_pkg::REG_HIGH:    prdata = {19'd0, cfg_q.high};
			tmef_pkg::REG_RATE:    prdata = {20'd0, cfg_q.rate};
			tmef_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout};
			tmef_pkg::REG_TRIP:    prdata = {24'd0, cfg_q.trip};
			tmef_pkg::REG_ALPHA:   prdata = {23'd0, cfg_q.alpha};
			default:               prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
